@@ hw/rtl/sebd_pkg.sv @@
// ----------------------------------------------------------------------------
// sebd_pkg
// Types, codes and marker letters shared by the serial event byte demux.
// ----------------------------------------------------------------------------
package sebd_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 32;
	localparam int NUMBER_W            = 32;
	localparam int BYTE_W              = 8;

	// marker letters, reset symbols and ETX
	localparam logic [7:0] CH_J   = 8'h4A;
	localparam logic [7:0] CH_M   = 8'h4D;
	localparam logic [7:0] CH_N   = 8'h4E;
	localparam logic [7:0] CH_O   = 8'h4F;
	localparam logic [7:0] CH_P   = 8'h50;
	localparam logic [7:0] CH_R   = 8'h52;
	localparam logic [7:0] CH_S   = 8'h53;
	localparam logic [7:0] CH_T   = 8'h54;
	localparam logic [7:0] CH_U   = 8'h55;
	localparam logic [7:0] CH_V   = 8'h56;
	localparam logic [7:0] CH_W   = 8'h57;
	localparam logic [7:0] CH_X   = 8'h58;
	localparam logic [7:0] CH_Y   = 8'h59;
	localparam logic [7:0] CH_Z   = 8'h5A;
	localparam logic [7:0] CH_ETX = 8'h03;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_SCAN  = 3'd1,
		EV_TRIG  = 3'd2,
		EV_STOP  = 3'd3,
		EV_WRONG = 3'd4,
		EV_END1  = 3'd5,
		EV_END2  = 3'd6
	} event_kind_t;

	typedef enum logic [2:0] {
		RT_MARK  = 3'd0,
		RT_CAP1  = 3'd1,
		RT_CAP2  = 3'd2,
		RT_REPLY = 3'd3,
		RT_DROP  = 3'd4
	} route_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic              reply_window;
	} sebd_item_t;

	typedef struct packed {
		event_kind_t         event_kind;
		route_t              route;
		logic [BYTE_W-1:0]   out_byte;
		logic [NUMBER_W-1:0] scan_point_number;
		logic [NUMBER_W-1:0] ext_trigger_number;
		logic                frame_end;
	} sebd_result_t;

endpackage

@@ hw/rtl/serial_event_byte_demux.sv @@
// ----------------------------------------------------------------------------
// serial_event_byte_demux
// Splits a received serial byte stream into marker events, two capture
// windows and a reply channel, one result per byte.
//
//   channel | dir | tdata                                   | tuser            | tlast
//   s_      | in  | rx_byte[7:0]                            | reply_window[0]  | -
//   m_      | out | out_byte, scan_point_number, ext_trig.. | event_kind,route | frame_end
//
// one byte per cycle sustained while m_tready does not stall; path (input register, then
// decode into the result register)
// the result register reloads in the cycle it is taken; with both registers
// full a stall on m_tready holds s_tready low in the same cycle
// arst_n resets the symbol history and clears both valid bits, window flags and counters
// ----------------------------------------------------------------------------
module serial_event_byte_demux import sebd_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] reply_window
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [7:0] out_byte, [39:8] scan_point_number,
	                               // [71:40] ext_trigger_number
	output logic [5:0]  m_tuser,   // [2:0] event_kind, [5:3] route
	output logic        m_tlast    // frame_end
);

	logic         in_valid_q;
	sebd_item_t   item_s1;
	logic         out_valid_q;
	sebd_result_t result_s2;
	sebd_result_t result;
	logic         out_free;
	logic         advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = in_valid_q && out_free;
	assign s_tready = !in_valid_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				in_valid_q <= s_tvalid;
			if (out_free)
				out_valid_q <= in_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.rx_byte      <= s_tdata;
			item_s1.reply_window <= s_tuser[0];
		end
		if (advance)
			result_s2 <= result;
	end

	sebd_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {result_s2.ext_trigger_number, result_s2.scan_point_number,
	                   result_s2.out_byte};
	assign m_tuser  = {result_s2.route, result_s2.event_kind};
	assign m_tlast  = result_s2.frame_end;

endmodule

@@ hw/rtl/sebd_core.sv @@
// ----------------------------------------------------------------------------
// sebd_core
// Marker decode, symbol history, capture window flags and event counters.
// Result is combinational from the item and the state; state updates when step is high.
// ----------------------------------------------------------------------------
module sebd_core import sebd_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  sebd_item_t   item,
	output sebd_result_t result
);

	logic [7:0]             last_scan_q, last_trig_q, last_stop_q, last_wrong_q;
	logic                   cap1_open_q, cap2_open_q;
	logic [COUNT_WIDTH-1:0] scan_count_q, trig_count_q;

	logic [7:0]             last_scan_d, last_trig_d, last_stop_d, last_wrong_d;
	logic                   cap1_open_d, cap2_open_d;
	logic [COUNT_WIDTH-1:0] scan_count_d, trig_count_d;
	logic                   marker;
	event_kind_t            ev;
	route_t                 rt;
	logic [7:0]             c;

	assign c = item.rx_byte;

	always_comb begin
		last_scan_d  = last_scan_q;
		last_trig_d  = last_trig_q;
		last_stop_d  = last_stop_q;
		last_wrong_d = last_wrong_q;
		cap1_open_d  = cap1_open_q;
		cap2_open_d  = cap2_open_q;
		scan_count_d = scan_count_q;
		trig_count_d = trig_count_q;
		marker       = 1'b0;
		ev           = EV_NONE;
		priority if (c == CH_W || c == CH_X) begin
			cap1_open_d = 1'b1;
			if (c < last_scan_q) begin
				scan_count_d = scan_count_q + COUNT_WIDTH'(1);
				ev           = EV_SCAN;
			end
			last_scan_d = c;
			marker      = 1'b1;
		end else if (c == CH_S || c == CH_T) begin
			cap2_open_d = 1'b1;
			if (c < last_trig_q) begin
				trig_count_d = trig_count_q + COUNT_WIDTH'(1);
				ev           = EV_TRIG;
			end
			last_trig_d = c;
			marker      = 1'b1;
		end else if (c >= CH_J && c <= CH_M) begin
			if (c < last_stop_q)
				ev = EV_STOP;
			last_stop_d = c;
			marker      = 1'b1;
		end else if (c == CH_N || c == CH_O || c == CH_P || c == CH_R) begin
			if (c < last_wrong_q)
				ev = EV_WRONG;
			last_wrong_d = c;
			marker       = 1'b1;
		end else if (c == CH_Y || c == CH_Z) begin
			cap1_open_d = 1'b0;
			last_scan_d = c;
			ev          = EV_END1;
		end else if (c == CH_U || c == CH_V) begin
			cap2_open_d = 1'b0;
			last_trig_d = c;
			ev          = EV_END2;
		end else begin
			// any other byte only goes on to routing
			marker = 1'b0;
		end
	end

	// routing sees the window flags after this byte
	always_comb begin
		priority if (marker)
			rt = RT_MARK;
		else if (cap1_open_d)
			rt = RT_CAP1;
		else if (cap2_open_d)
			rt = RT_CAP2;
		else if (item.reply_window)
			rt = RT_REPLY;
		else
			rt = RT_DROP;
	end

	always_comb begin
		result.event_kind         = ev;
		result.route              = rt;
		result.out_byte           = c;
		result.scan_point_number  = NUMBER_W'(scan_count_d);
		result.ext_trigger_number = NUMBER_W'(trig_count_d);
		result.frame_end          = (rt == RT_REPLY) && (c == CH_ETX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scan_q  <= CH_Z;
			last_trig_q  <= CH_V;
			last_stop_q  <= CH_M;
			last_wrong_q <= CH_R;
			cap1_open_q  <= 1'b0;
			cap2_open_q  <= 1'b0;
			scan_count_q <= '0;
			trig_count_q <= '0;
		end else if (step) begin
			last_scan_q  <= last_scan_d;
			last_trig_q  <= last_trig_d;
			last_stop_q  <= last_stop_d;
			last_wrong_q <= last_wrong_d;
			cap1_open_q  <= cap1_open_d;
			cap2_open_q  <= cap2_open_d;
			scan_count_q <= scan_count_d;
			trig_count_q <= trig_count_d;
		end
	end

`ifndef SYNTHESIS
	a_scan_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.event_kind == EV_SCAN |=>
			scan_count_q == $past(scan_count_q) + COUNT_WIDTH'(1))
		else $error("scan point count did not advance on a scan event");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(scan_count_q) && $stable(trig_count_q))
		else $error("event counters moved without a transaction");

	a_open_one: assert property (@(posedge clk) disable iff (!arst_n)
		step && (item.rx_byte == CH_W || item.rx_byte == CH_X) |=> cap1_open_q)
		else $error("capture one window not opened by scan marker");

	a_frame_end_route: assert property (@(posedge clk) disable iff (!arst_n)
		result.frame_end |-> result.route == RT_REPLY && item.reply_window)
		else $error("frame end flagged outside the reply route");

	a_close_not_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result.event_kind == EV_END1 |-> result.route != RT_MARK && result.route != RT_CAP1)
		else $error("closing byte of capture one routed as marker or into capture one");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for serial_event_byte_demux. A short table of bytes
// walks the marker groups, window open and close letters, the reply channel
// and ETX, then random byte streams follow under four handshake phases. Each
// accepted byte is run through an in-bench model of the demux and every
// output transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import sebd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 350;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic [7:0]   rx;
		logic         reply;
		logic         typed;
		sebd_result_t res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	// model state
	logic [7:0]  scan_sym, trig_sym, stop_sym, wrong_sym;
	logic        win_one, win_two;
	logic [31:0] scan_cnt, trig_cnt;

	sebd_result_t pending_results[$];
	stim_row_t    byte_table[$];
	int           idle_pct  = 0;
	int           stall_pct = 0;
	int           fail_count = 0;
	int           checked   = 0;
	int           cycles    = 0;
	int           sent      = 0;

	serial_event_byte_demux dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic sebd_result_t demux_byte(input logic [7:0] c, input logic reply);
		sebd_result_t r;
		logic         marker;
		r.event_kind = EV_NONE;
		r.route      = RT_DROP;
		r.frame_end  = 1'b0;
		marker       = 1'b0;
		if (c == CH_W || c == CH_X) begin
			win_one = 1'b1;
			if (c < scan_sym) begin
				scan_cnt     = scan_cnt + 32'd1;
				r.event_kind = EV_SCAN;
			end
			scan_sym = c;
			marker   = 1'b1;
		end else if (c == CH_S || c == CH_T) begin
			win_two = 1'b1;
			if (c < trig_sym) begin
				trig_cnt     = trig_cnt + 32'd1;
				r.event_kind = EV_TRIG;
			end
			trig_sym = c;
			marker   = 1'b1;
		end else if (c >= CH_J && c <= CH_M) begin
			if (c < stop_sym)
				r.event_kind = EV_STOP;
			stop_sym = c;
			marker   = 1'b1;
		end else if (c == CH_N || c == CH_O || c == CH_P || c == CH_R) begin
			if (c < wrong_sym)
				r.event_kind = EV_WRONG;
			wrong_sym = c;
			marker    = 1'b1;
		end else if (c == CH_Y || c == CH_Z) begin
			win_one      = 1'b0;
			scan_sym     = c;
			r.event_kind = EV_END1;
		end else if (c == CH_U || c == CH_V) begin
			win_two      = 1'b0;
			trig_sym     = c;
			r.event_kind = EV_END2;
		end
		// close letters fall through to routing like ordinary bytes
		if (marker)
			r.route = RT_MARK;
		else if (win_one)
			r.route = RT_CAP1;
		else if (win_two)
			r.route = RT_CAP2;
		else if (reply) begin
			r.route     = RT_REPLY;
			r.frame_end = (c == CH_ETX);
		end
		r.out_byte           = c;
		r.scan_point_number  = scan_cnt;
		r.ext_trigger_number = trig_cnt;
		return r;
	endfunction

	function automatic void add_byte(input logic [7:0] c, input logic reply);
		stim_row_t row;
		row       = '0;
		row.rx    = c;
		row.reply = reply;
		byte_table.push_back(row);
	endfunction

	function automatic void add_known(input logic [7:0] c, input logic reply,
			input event_kind_t ev, input route_t rt, input logic [31:0] sp,
			input logic [31:0] et, input logic fe);
		stim_row_t row;
		row.rx                     = c;
		row.reply                  = reply;
		row.typed                  = 1'b1;
		row.res.event_kind         = ev;
		row.res.route              = rt;
		row.res.out_byte           = c;
		row.res.scan_point_number  = sp;
		row.res.ext_trigger_number = et;
		row.res.frame_end          = fe;
		byte_table.push_back(row);
	endfunction

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input stim_row_t row);
		sebd_result_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= row.rx;
		s_tuser  <= row.reply;
		do @(posedge clk); while (!s_tready);
		predicted = demux_byte(row.rx, row.reply);
		pending_results.push_back(row.typed ? row.res : predicted);
		sent++;
		@(negedge clk);
	endtask

	// hold the sender off until every prediction has been matched
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		sebd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected output transaction, out_byte %0h", m_tdata[7:0]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (m_tuser[2:0] !== want.event_kind) begin
					$error("event_kind: expected %0d, actual %0d", want.event_kind,
						m_tuser[2:0]);
					fail_count++;
				end
				if (m_tuser[5:3] !== want.route) begin
					$error("route: expected %0d, actual %0d", want.route, m_tuser[5:3]);
					fail_count++;
				end
				if (m_tdata[7:0] !== want.out_byte) begin
					$error("out_byte: expected %0h, actual %0h", want.out_byte,
						m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[39:8] !== want.scan_point_number) begin
					$error("scan_point_number: expected %0d, actual %0d",
						want.scan_point_number, m_tdata[39:8]);
					fail_count++;
				end
				if (m_tdata[71:40] !== want.ext_trigger_number) begin
					$error("ext_trigger_number: expected %0d, actual %0d",
						want.ext_trigger_number, m_tdata[71:40]);
					fail_count++;
				end
				if (m_tlast !== want.frame_end) begin
					$error("frame_end: expected %0d, actual %0d", want.frame_end, m_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int        phase;
		int        pick;
		stim_row_t row;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		scan_sym  = CH_Z;
		trig_sym  = CH_V;
		stop_sym  = CH_M;
		wrong_sym = CH_R;
		win_one   = 1'b0;
		win_two   = 1'b0;
		scan_cnt  = '0;
		trig_cnt  = '0;

		// walk of the marker groups from reset
		add_known(CH_W, 1'b0, EV_SCAN, RT_MARK, 32'd1, 32'd0, 1'b0);
		add_known(CH_X, 1'b0, EV_NONE, RT_MARK, 32'd1, 32'd0, 1'b0);
		add_known(8'h41, 1'b0, EV_NONE, RT_CAP1, 32'd1, 32'd0, 1'b0);
		add_known(CH_S, 1'b0, EV_TRIG, RT_MARK, 32'd1, 32'd1, 1'b0);
		add_byte(CH_Z, 1'b1);   // closes window one, lands in window two
		add_byte(8'h00, 1'b1);
		add_byte(CH_V, 1'b1);
		add_known(CH_ETX, 1'b1, EV_NONE, RT_REPLY, 32'd1, 32'd1, 1'b1);
		add_known(CH_ETX, 1'b0, EV_NONE, RT_DROP, 32'd1, 32'd1, 1'b0);
		add_known(CH_J, 1'b0, EV_STOP, RT_MARK, 32'd1, 32'd1, 1'b0);
		add_known(CH_M, 1'b0, EV_NONE, RT_MARK, 32'd1, 32'd1, 1'b0);
		add_byte(CH_M - 8'd2, 1'b0);
		add_known(CH_N, 1'b0, EV_WRONG, RT_MARK, 32'd1, 32'd1, 1'b0);
		add_known(CH_R, 1'b0, EV_NONE, RT_MARK, 32'd1, 32'd1, 1'b0);
		add_byte(CH_P, 1'b0);
		add_byte(CH_O, 1'b1);
		add_byte(CH_R - 8'd1, 1'b1);   // the letter between the wrong-scan letters
		add_byte(8'hFF, 1'b1);
		add_byte(CH_Y, 1'b0);
		add_byte(CH_U, 1'b1);
		add_byte(CH_T, 1'b0);
		add_byte(CH_S, 1'b0);
		add_byte(CH_X, 1'b0);
		add_byte(CH_W, 1'b0);
		add_byte(8'h80, 1'b1);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (byte_table[i])
			send_byte(byte_table[i]);
		drain_results();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			repeat (PHASE_ITEMS) begin
				row  = '0;
				pick = $urandom_range(0, 99);
				// half the bytes come from the letters J to Z so the group history moves
				if (pick < 50)
					row.rx = 8'($urandom_range(CH_J, CH_Z));
				else if (pick < 60)
					row.rx = CH_ETX;
				else
					row.rx = 8'($urandom_range(0, 255));
				row.reply = 1'($urandom_range(0, 1));
				send_byte(row);
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d bytes (%0d from the table), %0d output transactions checked",
			sent, byte_table.size(), checked);
		$display("four handshake phases: free flow, sender gaps, receiver stalls, both");
		if (fail_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/sebd_pkg.sv
hw/rtl/sebd_core.sv
hw/rtl/serial_event_byte_demux.sv
tb/testbench.sv
